// ===== hdl/bte_pkg.sv =====
`timescale 1ns / 1ps
package bte_pkg;

  localparam logic [1:0] OP_NODE     = 2'd0;
  localparam logic [1:0] OP_ROOT     = 2'd1;
  localparam logic [1:0] OP_FEATURE  = 2'd2;
  localparam logic [1:0] OP_CLASSIFY = 2'd3;

  localparam logic [1:0] REG_TREE_COUNT = 2'd0;
  localparam logic [1:0] REG_LEAF_SCALE = 2'd1;
  localparam logic [1:0] REG_BIAS       = 2'd2;

  localparam logic [9:0]  ABSENT_INDEX   = 10'd1023;
  localparam logic [63:0] EXP_STEP_Q32   = 64'd4034748382;
  localparam logic signed [31:0] SIG_LOW  = -32'sd524288;
  localparam logic signed [31:0] SIG_HIGH = 32'sd524288;

  typedef struct packed {
    logic              leaf;
    logic [2:0]        feat;
    logic signed [31:0] val;
    logic [9:0]        left;
    logic [9:0]        right;
  } node_t;

  typedef logic [15:0] sig_table_t [256];

  // long division, table build only
  function automatic logic [63:0] div_u64(input logic [63:0] num, input logic [63:0] den);
    logic [63:0] q;
    logic [64:0] r;
    q = '0;
    r = '0;
    for (int i = 63; i >= 0; i--) begin
      r = {r[63:0], num[i]};
      if (r >= {1'b0, den}) begin
        r = r - {1'b0, den};
        q[i] = 1'b1;
      end
    end
    return q;
  endfunction

  function automatic sig_table_t build_sig_table();
    sig_table_t tab;
    logic [63:0] e;
    logic [63:0] den;
    logic [63:0] s;
    e = 64'd1 << 32;
    for (int k = 0; k <= 128; k++) begin
      den = (64'd1 << 32) + e;
      s = div_u64((64'd1 << 48) + (den >> 1), den);
      if (k < 128) tab[128 + k] = (s > 64'd65535) ? 16'hFFFF : s[15:0];
      if (k > 0) tab[128 - k] = 16'(64'd65536 - s);
      e = (e * EXP_STEP_Q32 + (64'd1 << 31)) >> 32;
    end
    return tab;
  endfunction

  localparam sig_table_t SIG_TABLE = build_sig_table();

endpackage

// ===== hdl/boosted_tree_ensemble_classifier_unit.sv =====
`timescale 1ns / 1ps
// Channel   Dir  Handshake              Contents
// s_*       in   s_tvalid/s_tready      request: opcode in tuser, node/root/feature data
// m_*       out  m_tvalid/m_tready      result: logit, probability, status
// apb       in   psel/penable/pready    tree_count, leaf_scale, bias
// Write requests complete when accepted. A classify request reads, per tree, the root
// (S_TREE, S_ROOT), then the node memory per level (S_VISIT, S_NODE), and accumulates at a
// leaf (S_ACC); the node memory read per level sets the rate.
// rst resets control state and the APB registers only; memories are undefined until written.
// A finished result waits in the output register; new requests are taken then.
module boosted_tree_ensemble_classifier_unit #(
  parameter int NODES        = 1024,
  parameter int MAX_TREES    = 64,
  parameter int NUM_FEATURES = 8,
  parameter int DEPTH_LIMIT  = 16
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  // address[9:0], leaf_flag[10], feature_select[13:11], value[45:14],
  // left_index[55:46], right_index[65:56], zero[71:66]
  input  logic [71:0] s_tdata,
  // opcode[1:0]
  input  logic [1:0]  s_tuser,
  output logic        m_tvalid,
  input  logic        m_tready,
  // logit[31:0], probability[47:32], status[48], zero[55:49]
  output logic [55:0] m_tdata,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  localparam int NAW = $clog2(NODES);
  localparam int TAW = (MAX_TREES > 1) ? $clog2(MAX_TREES) : 1;
  localparam int FAW = (NUM_FEATURES > 1) ? $clog2(NUM_FEATURES) : 1;
  localparam int TCW = $clog2(MAX_TREES + 1);
  localparam int DW  = $clog2(DEPTH_LIMIT + 2);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_TREE  = 3'd1;
  localparam logic [2:0] S_ROOT  = 3'd2;
  localparam logic [2:0] S_VISIT = 3'd3;
  localparam logic [2:0] S_NODE  = 3'd4;
  localparam logic [2:0] S_ACC   = 3'd5;
  localparam logic [2:0] S_FIN   = 3'd6;

  logic [6:0]         tree_count;
  logic [23:0]        leaf_scale;
  logic signed [31:0] bias;

  bte_pkg::node_t     node_mem [NODES];
  logic [9:0]         root_mem [MAX_TREES];
  logic signed [31:0] feature_store [NUM_FEATURES];

  bte_pkg::node_t     node_q;
  logic [9:0]         root_q;
  logic [2:0]         state;
  logic [TCW-1:0]     tree_idx;
  logic [TCW-1:0]     tree_total;
  logic [9:0]         cur_idx;
  logic [DW-1:0]      depth;
  logic signed [31:0] acc;
  logic               over;
  logic signed [57:0] prod;
  logic               accept;
  logic [9:0]         in_addr;
  bte_pkg::node_t     in_node;
  logic               idx_absent;
  logic signed [31:0] feat_val;
  logic signed [42:0] sum;
  logic signed [31:0] acc_next;
  logic [7:0]         sig_idx;
  logic [31:0]        sig_sum;

  assign pready   = 1'b1;
  assign s_tready = (state == S_IDLE);
  assign accept   = s_tvalid && s_tready;
  assign in_addr  = s_tdata[9:0];
  assign in_node  = '{leaf: s_tdata[10], feat: s_tdata[13:11], val: s_tdata[45:14],
                      left: s_tdata[55:46], right: s_tdata[65:56]};

  assign tree_total = ({25'd0, tree_count} > MAX_TREES) ? TCW'(MAX_TREES) : TCW'(tree_count);
  assign idx_absent = (cur_idx == bte_pkg::ABSENT_INDEX) || ({22'd0, cur_idx} >= NODES);
  assign feat_val   = ({29'd0, node_q.feat} < NUM_FEATURES) ?
                      feature_store[FAW'(node_q.feat)] : 32'sd0;
  assign sum        = 43'(acc) + 43'((prod + 58'sd32768) >>> 16);
  assign acc_next   = (sum > 43'sd2147483647) ? 32'sh7FFFFFFF :
                      (sum < -43'sd2147483648) ? 32'sh80000000 : sum[31:0];
  assign sig_sum    = acc + 32'sd524288;
  assign sig_idx    = (acc < bte_pkg::SIG_LOW) ? 8'd0 :
                      (acc >= bte_pkg::SIG_HIGH) ? 8'd255 : sig_sum[19:12];

  always_comb begin
    unique case (paddr[3:2])
      bte_pkg::REG_TREE_COUNT: prdata = {25'd0, tree_count};
      bte_pkg::REG_LEAF_SCALE: prdata = {8'd0, leaf_scale};
      bte_pkg::REG_BIAS:       prdata = bias;
      default:                 prdata = 32'd0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      tree_count <= 7'd0;
      leaf_scale <= 24'd19661;
      bias       <= 32'sd32768;
    end else if (psel && penable && pwrite && pready) begin
      case (paddr[3:2])
        bte_pkg::REG_TREE_COUNT: tree_count <= pwdata[6:0];
        bte_pkg::REG_LEAF_SCALE: leaf_scale <= pwdata[23:0];
        bte_pkg::REG_BIAS:       bias       <= pwdata;
        default: ;
      endcase
    end
  end

  // memories and feature registers
  always_ff @(posedge clk) begin
    if (accept && s_tuser == bte_pkg::OP_NODE && {22'd0, in_addr} < NODES)
      node_mem[NAW'(in_addr)] <= in_node;
    if (accept && s_tuser == bte_pkg::OP_ROOT && {22'd0, in_addr} < MAX_TREES)
      root_mem[TAW'(in_addr)] <= in_node.left;
    if (accept && s_tuser == bte_pkg::OP_FEATURE && {22'd0, in_addr} < NUM_FEATURES)
      feature_store[FAW'(in_addr)] <= in_node.val;
    if (state == S_VISIT)
      node_q <= node_mem[NAW'(cur_idx)];
    if (state == S_TREE)
      root_q <= root_mem[TAW'(tree_idx)];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      m_tvalid <= 1'b0;
    end else begin
      if (state == S_FIN && (!m_tvalid || m_tready)) m_tvalid <= 1'b1;
      else if (m_tready) m_tvalid <= 1'b0;
      unique case (state)
        S_IDLE: begin
          if (accept && s_tuser == bte_pkg::OP_CLASSIFY) begin
            acc      <= bias;
            over     <= 1'b0;
            tree_idx <= '0;
            state    <= S_TREE;
          end
        end
        S_TREE: state <= (tree_idx == tree_total) ? S_FIN : S_ROOT;
        S_ROOT: begin
          cur_idx <= root_q;
          depth   <= '0;
          state   <= S_VISIT;
        end
        S_VISIT: begin
          if (idx_absent) begin
            tree_idx <= tree_idx + 1'b1;
            state    <= S_TREE;
          end else if ({{(32-DW){1'b0}}, depth} > DEPTH_LIMIT) begin
            over     <= 1'b1;
            tree_idx <= tree_idx + 1'b1;
            state    <= S_TREE;
          end else begin
            state <= S_NODE;
          end
        end
        S_NODE: begin
          if (node_q.leaf) begin
            prod  <= $signed({1'b0, leaf_scale}) * $signed(node_q.val);
            state <= S_ACC;
          end else begin
            cur_idx <= (feat_val <= $signed(node_q.val)) ? node_q.left : node_q.right;
            depth   <= depth + 1'b1;
            state   <= S_VISIT;
          end
        end
        S_ACC: begin
          acc      <= acc_next;
          tree_idx <= tree_idx + 1'b1;
          state    <= S_TREE;
        end
        S_FIN: begin
          if (!m_tvalid || m_tready) begin
            m_tdata <= {7'd0, over, bte_pkg::SIG_TABLE[sig_idx], acc};
            state   <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule
